>>> rtl/core/ppla_pkg.sv
// shared types, codes and constants of the pixel parameter location allocator
package ppla_pkg;

    localparam int SLOTS_DEF  = 32;
    localparam int TBL_DEPTH  = 32;
    localparam int TBL_AW     = 5;
    localparam int ACT_W      = 3;
    localparam int IDX_W      = 8;
    localparam int OFF_W      = 5;
    localparam int CNT_W      = 6;
    localparam int MASK_W     = 32;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MARK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ASSIGN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_COUNT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMASK   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] attr_index;
        logic [OFF_W-1:0] setting_offset;
        logic             setting_flat;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] location;
        logic             is_flat;
        logic             is_custom;
        logic [ERR_W-1:0] error_code;
    } t_rsp;

    typedef struct packed {
        logic             flat;
        logic [OFF_W-1:0] offset;
    } t_entry;

    // looked-up word handed from the input register to the allocator
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] slot;
        logic             flat;
        logic             custom;
        logic             no_entry;
        logic             pixel;
    } t_lkp;

endpackage

>>> rtl/core/pixel_param_location_alloc_top.sv
// top level of the pixel parameter location allocator
// an accepted word is held in the input register, then passes the allocator logic into the result register
// throughput: one word per clock while busy is low; set by the single pass through the group ram's registered
// read, the free-slot priority encoder and the result register
// reset: synchronous active low; clears the used map, group valid bits and mark count, and
// puts config back to its defaults; busy stays high through reset and drops once the ready register is set after it
// results cannot be stalled
module pixel_param_location_alloc_top import ppla_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_start,
    input  t_req                  i_req,
    output logic                  o_busy,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp
);

    localparam int SW   = $clog2(SLOTS);
    localparam int GA_W = SW + 1;

    t_lkp            lkp;
    logic            lkp_vld;
    logic [GA_W-1:0] grp_raddr;
    logic [SW-1:0]   grp_rdata;
    logic            grp_we;
    logic [GA_W-1:0] grp_waddr;
    logic [SW-1:0]   grp_wdata;

    ppla_lookup #(
        .SLOTS(SLOTS)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_lkp       (lkp),
        .o_lkp_vld   (lkp_vld),
        .o_grp_raddr (grp_raddr)
    );

    // group locations, valid bits live in the allocator
    ppla_ram #(
        .WIDTH(SW),
        .DEPTH(2 * SLOTS)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (grp_we),
        .i_waddr (grp_waddr),
        .i_wdata (grp_wdata),
        .i_raddr (grp_raddr),
        .o_rdata (grp_rdata)
    );

    ppla_alloc #(
        .SLOTS(SLOTS)
    ) u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lkp       (lkp),
        .i_lkp_vld   (lkp_vld),
        .i_grp_raddr (grp_raddr),
        .i_grp_rdata (grp_rdata),
        .o_grp_we    (grp_we),
        .o_grp_waddr (grp_waddr),
        .o_grp_wdata (grp_wdata),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

>>> rtl/core/ppla_ram.sv
// generic single-port-write ram with registered read
module ppla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ppla_lookup.sv
// config registers, settings table, slot lookup and input register
module ppla_lookup import ppla_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                        i_start,
    input  t_req                        i_req,
    output logic                        o_busy,
    output t_lkp                        o_lkp,
    output logic                        o_lkp_vld,
    output logic [$clog2(SLOTS):0]      o_grp_raddr
);

    localparam int SW = $clog2(SLOTS);

    logic              r_pixel;
    logic [CNT_W-1:0]  r_in_cnt;
    logic [MASK_W-1:0] r_cmask;
    logic              r_rdy;
    t_entry            r_tbl [TBL_DEPTH];
    t_lkp              r_lkp;
    logic              r_vld;

    logic              accept;
    logic              hi_idx;
    logic              in_tbl;
    logic              use_tbl;
    t_entry            ent;
    t_lkp              n_lkp;

    assign accept = i_start && r_rdy;
    assign o_busy = !r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel  <= 1'b1;
            r_in_cnt <= '0;
            r_cmask  <= '0;
            r_rdy    <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            r_vld <= accept;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PIXEL:   r_pixel  <= i_cfg_wdata[0];
                    CFG_INCOUNT: r_in_cnt <= i_cfg_wdata[CNT_W-1:0];
                    CFG_CMASK:   r_cmask  <= i_cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // table write takes effect at the accepting edge, ahead of the next lookup
    always_ff @(posedge i_clk) begin
        if (accept && i_req.action == ACT_WRITE && !hi_idx) begin
            r_tbl[i_req.attr_index[TBL_AW-1:0]] <= '{flat: i_req.setting_flat,
                                                    offset: i_req.setting_offset};
        end
    end

    always_comb begin
        hi_idx  = |i_req.attr_index[IDX_W-1:TBL_AW];
        in_tbl  = i_req.attr_index < {{(IDX_W-CNT_W){1'b0}}, r_in_cnt};
        use_tbl = in_tbl && !hi_idx;
        ent     = r_tbl[i_req.attr_index[TBL_AW-1:0]];

        n_lkp.action   = i_req.action;
        n_lkp.idx      = i_req.attr_index;
        n_lkp.custom   = !hi_idx && r_cmask[i_req.attr_index[TBL_AW-1:0]];
        n_lkp.no_entry = in_tbl && hi_idx;
        n_lkp.flat     = use_tbl && ent.flat && !n_lkp.custom;
        n_lkp.slot     = use_tbl ? {{(IDX_W-OFF_W){1'b0}}, ent.offset} : i_req.attr_index;
        n_lkp.pixel    = r_pixel;
    end

    // group ram read is launched here so its data lines up with the input register
    assign o_grp_raddr = {n_lkp.slot[SW-1:0], n_lkp.flat};

    always_ff @(posedge i_clk) begin
        r_lkp <= n_lkp;
    end

    assign o_lkp     = r_lkp;
    assign o_lkp_vld = r_vld;

endmodule

>>> rtl/core/ppla_alloc.sv
// used-slot map, group allocation, mark count and result register
module ppla_alloc import ppla_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lkp                       i_lkp,
    input  logic                       i_lkp_vld,
    input  logic [$clog2(SLOTS):0]     i_grp_raddr,
    input  logic [$clog2(SLOTS)-1:0]   i_grp_rdata,
    output logic                       o_grp_we,
    output logic [$clog2(SLOTS):0]     o_grp_waddr,
    output logic [$clog2(SLOTS)-1:0]   o_grp_wdata,
    output logic                       o_rsp_valid,
    output t_rsp                       o_rsp
);

    localparam int SW   = $clog2(SLOTS);
    localparam int GA_W = SW + 1;
    localparam int GD   = 2 * SLOTS;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] SLOT_LIM = IDX_W'(SLOTS);
    localparam logic [CW-1:0]    CNT_MAX  = CW'(SLOTS);

    logic [SLOTS-1:0] r_used;
    logic [GD-1:0]    r_gvld;
    logic [CW-1:0]    r_cnt;
    logic             r_fwd_hit;
    logic [SW-1:0]    r_fwd_data;
    t_rsp             r_rsp;
    logic             r_rsp_v;
    logic             r_asg_ok;

    logic [SLOTS-1:0] n_used;
    logic [GD-1:0]    n_gvld;
    logic [CW-1:0]    n_cnt;
    t_rsp             n_rsp;
    logic             n_res;
    logic             n_asg_ok;
    logic [GA_W-1:0]  grp;
    logic [GA_W-1:0]  pgrp;
    logic [SW-1:0]    gloc;
    logic [SW-1:0]    aloc;
    logic             ff_found;
    logic [SW-1:0]    ff_idx;
    logic             slot_ok;
    logic             we;

    assign grp     = {i_lkp.slot[SW-1:0], i_lkp.flat};
    assign pgrp    = {i_lkp.slot[SW-1:0], !i_lkp.flat};
    assign gloc    = r_fwd_hit ? r_fwd_data : i_grp_rdata;
    assign slot_ok = i_lkp.slot < SLOT_LIM;

    // lowest free slot
    always_comb begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                ff_found = 1'b1;
                ff_idx   = SW'(s);
            end
        end
    end

    always_comb begin
        n_used   = r_used;
        n_gvld   = r_gvld;
        n_cnt    = r_cnt;
        n_res    = 1'b0;
        n_asg_ok = 1'b0;
        we       = 1'b0;
        aloc     = i_lkp.slot[SW-1:0];
        n_rsp.location   = i_lkp.idx;
        n_rsp.is_flat    = 1'b0;
        n_rsp.is_custom  = 1'b0;
        n_rsp.error_code = ERR_OK;

        if (i_lkp_vld) begin
            case (i_lkp.action) inside
                ACT_CLEAR: begin
                    n_used = '0;
                    n_gvld = '0;
                    n_cnt  = '0;
                end
                ACT_MARK, ACT_ASSIGN, ACT_LOOKUP: begin
                    n_res = 1'b1;
                    if (i_lkp.pixel) begin
                        n_rsp.is_flat   = i_lkp.flat;
                        n_rsp.is_custom = i_lkp.custom;
                        if (i_lkp.action == ACT_MARK && r_cnt >= CNT_MAX) begin
                            n_rsp.error_code = ERR_COUNT;
                        end else if (i_lkp.no_entry) begin
                            n_rsp.error_code = ERR_RANGE;
                        end else if (i_lkp.action == ACT_LOOKUP) begin
                            n_rsp.location = i_lkp.slot;
                        end else if (!slot_ok) begin
                            n_rsp.error_code = ERR_RANGE;
                            n_rsp.location   = i_lkp.slot;
                        end else if (i_lkp.action == ACT_MARK) begin
                            n_used[i_lkp.slot[SW-1:0]] = 1'b1;
                            n_cnt          = r_cnt + CW'(1);
                            n_rsp.location = i_lkp.slot;
                        end else if (r_gvld[grp]) begin
                            n_rsp.location = IDX_W'(gloc);
                            n_asg_ok       = 1'b1;
                        end else begin
                            // partner group already owns the mapped slot
                            if (r_gvld[pgrp]) begin
                                aloc = ff_idx;
                            end
                            if (r_gvld[pgrp] && !ff_found) begin
                                n_rsp.error_code = ERR_FULL;
                                n_rsp.location   = '0;
                            end else begin
                                we             = 1'b1;
                                n_gvld[grp]    = 1'b1;
                                n_used[aloc]   = 1'b1;
                                n_rsp.location = IDX_W'(aloc);
                                n_asg_ok       = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_grp_we    = we;
    assign o_grp_waddr = grp;
    assign o_grp_wdata = aloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_gvld    <= '0;
            r_cnt     <= '0;
            r_fwd_hit <= 1'b0;
            r_rsp_v   <= 1'b0;
            r_asg_ok  <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_gvld    <= n_gvld;
            r_cnt     <= n_cnt;
            // ram read at the same edge as this write returns the old word
            r_fwd_hit <= we && (grp == i_grp_raddr);
            r_rsp_v   <= n_res;
            r_asg_ok  <= n_asg_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= aloc;
        r_rsp      <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_v;
    assign o_rsp       = r_rsp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("mark count above slot count");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lkp_vld && (i_lkp.action == ACT_MARK || i_lkp.action == ACT_ASSIGN ||
                       i_lkp.action == ACT_LOOKUP)) |=> o_rsp_valid)
        else $error("result word missing");

    a_asg_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_v && r_asg_ok) |-> r_used[o_rsp.location[SW-1:0]])
        else $error("assigned location not in used map");

    a_full_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_v && o_rsp.error_code == ERR_FULL) |-> (&r_used))
        else $error("no-free-slot error with a free slot");

endmodule

>>> dv/ppla_location_checker.sv
// checker for the pixel parameter location allocator: predicts each result word and compares
`timescale 1ns / 100ps

module ppla_location_checker import ppla_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_req                  i_req,
    input  logic                  i_rsp_valid,
    input  t_rsp                  i_rsp,
    output int                    o_fault_count,
    output int                    o_owed_count
);

    logic             pixel_on;
    logic [CNT_W-1:0] in_count;
    logic [MASK_W-1:0] cmask;

    t_entry           settings [TBL_DEPTH];
    logic [SLOTS-1:0] used_map;
    logic             grp_valid [2*SLOTS];
    logic [IDX_W-1:0] grp_loc [2*SLOTS];
    int               marks;

    t_rsp owed_rsp [$];
    int   fault_count = 0;
    int   owed_count = 0;

    assign o_fault_count = fault_count;
    assign o_owed_count  = owed_count;

    function automatic void clear_alloc();
        used_map = '0;
        for (int g = 0; g < 2*SLOTS; g++) begin
            grp_valid[g] = 1'b0;
            grp_loc[g]   = '0;
        end
        marks = 0;
    endfunction

    // returns 1 when the word produces a result, with that result in rsp
    function automatic bit allocate_location(input t_req r, output t_rsp rsp);
        int idx;
        int slot;
        int grp;
        int s;
        int loc;
        bit flat;
        bit custom;
        bit no_entry;
        rsp = '0;
        idx = r.attr_index;
        case (r.action)
            ACT_CLEAR: begin
                clear_alloc();
                return 1'b0;
            end
            ACT_WRITE: begin
                if (idx < TBL_DEPTH) begin
                    settings[idx].flat   = r.setting_flat;
                    settings[idx].offset = r.setting_offset;
                end
                return 1'b0;
            end
            ACT_MARK, ACT_ASSIGN, ACT_LOOKUP: ;
            default: return 1'b0;
        endcase

        if (!pixel_on) begin
            rsp.location = r.attr_index;
            return 1'b1;
        end

        custom   = (idx < MASK_W) ? cmask[idx] : 1'b0;
        no_entry = (idx < in_count) && (idx >= TBL_DEPTH);
        slot     = idx;
        flat     = 1'b0;
        if (idx < in_count && !no_entry) begin
            slot = settings[idx].offset;
            flat = settings[idx].flat && !custom;
        end
        rsp.is_flat   = flat;
        rsp.is_custom = custom;
        loc = 0;

        // mark overflow is checked ahead of the slot range
        if (r.action == ACT_MARK && marks >= SLOTS) begin
            rsp.error_code = ERR_COUNT;
            loc = idx;
        end else if (no_entry) begin
            rsp.error_code = ERR_RANGE;
            loc = idx;
        end else if (r.action == ACT_LOOKUP) begin
            loc = slot;
        end else if (slot >= SLOTS) begin
            rsp.error_code = ERR_RANGE;
            loc = slot;
        end else if (r.action == ACT_MARK) begin
            used_map[slot] = 1'b1;
            marks++;
            loc = slot;
        end else begin
            grp = slot * 2 + int'(flat);
            if (grp_valid[grp]) begin
                loc = grp_loc[grp];
            end else begin
                s = slot;
                // partner group already owns the mapped slot: take the lowest free one
                if (grp_valid[grp ^ 1]) begin
                    s = 0;
                    while (s < SLOTS && used_map[s])
                        s++;
                end
                if (s >= SLOTS) begin
                    rsp.error_code = ERR_FULL;
                    loc = 0;
                end else begin
                    grp_valid[grp] = 1'b1;
                    grp_loc[grp]   = IDX_W'(s);
                    used_map[s]    = 1'b1;
                    loc = s;
                end
            end
        end
        rsp.location = IDX_W'(loc);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            pixel_on = 1'b1;
            in_count = '0;
            cmask    = '0;
            clear_alloc();
            owed_rsp.delete();
        end else begin
            if (i_rsp_valid) begin
                if (owed_rsp.size() == 0) begin
                    fault_count++;
                    $display("%0t: want no result, got %0d/%0b/%0b/%0d",
                             $time, i_rsp.location, i_rsp.is_flat, i_rsp.is_custom,
                             i_rsp.error_code);
                end else begin
                    want = owed_rsp.pop_front();
                    if (want.location !== i_rsp.location || want.is_flat !== i_rsp.is_flat ||
                        want.is_custom !== i_rsp.is_custom ||
                        want.error_code !== i_rsp.error_code) begin
                        fault_count++;
                        $display("%0t: want %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                                 $time, want.location, want.is_flat, want.is_custom,
                                 want.error_code, i_rsp.location, i_rsp.is_flat,
                                 i_rsp.is_custom, i_rsp.error_code);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PIXEL:   pixel_on = i_cfg_wdata[0];
                    CFG_INCOUNT: in_count = i_cfg_wdata[CNT_W-1:0];
                    CFG_CMASK:   cmask = i_cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (allocate_location(i_req, want))
                    owed_rsp.push_back(want);
            end
        end
        owed_count = owed_rsp.size();
    end

endmodule

>>> dv/pixel_param_location_alloc_top_test.sv
// stimulus and verdict for the pixel parameter location allocator
`timescale 1ns / 100ps

module pixel_param_location_alloc_top_test;
    import ppla_pkg::*;

    localparam int LIMIT = 400000;
    localparam int PHASES = 10;
    localparam int PHASE_WORDS = 30;
    localparam int REQ_W = $bits(t_req);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  start;
    t_req                  req;
    logic                  busy;
    logic                  rsp_valid;
    t_rsp                  rsp;

    int faults;
    int owed;
    int cycles = 0;
    bit gaps_on;
    int count_now;
    int phase_words;

    pixel_param_location_alloc_top #(.SLOTS(SLOTS_DEF)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_start     (start),
        .i_req       (req),
        .o_busy      (busy),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    ppla_location_checker #(.SLOTS(SLOTS_DEF)) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp         (rsp),
        .o_fault_count (faults),
        .o_owed_count  (owed)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // returns at the edge that takes the word, or after the gap that follows it; start stays high unless a gap follows
    task automatic issue(input logic [ACT_W-1:0] act, input int idx, input int off,
                         input int flat);
        t_req r;
        logic [REQ_W-1:0] junk;
        int gap;
        r.action         = act;
        r.attr_index     = IDX_W'(idx);
        r.setting_offset = OFF_W'(off);
        r.setting_flat   = flat[0];
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        phase_words++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            junk = REQ_W'($urandom);
            start <= 1'b0;
            req   <= junk;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic ask(input logic [ACT_W-1:0] act, input int idx);
        issue(act, idx, $urandom_range(0, 31), $urandom_range(0, 1));
    endtask

    task automatic noise();
        ask(ACT_W'($urandom_range(0, 2**ACT_W - 1)), $urandom_range(0, 255));
    endtask

    function automatic int pick_index();
        if (count_now > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, count_now - 1);
        else if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 40);
        else
            return $urandom_range(0, 255);
    endfunction

    // hold off until every owed word is back, then let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (owed != 0);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input bit pix, input int cnt, input logic [MASK_W-1:0] mask);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PIXEL;
        cfg_wdata <= {31'($urandom), pix};
        @(posedge clk);
        cfg_idx   <= CFG_INCOUNT;
        cfg_wdata <= {26'($urandom), 6'(cnt)};
        @(posedge clk);
        cfg_idx   <= CFG_CMASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_idx   <= CFG_SPARE;
        cfg_wdata <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_now = cnt;
    endtask

    // may clear first, then marks then assigns the same inputs in the same order, with lookups and noise mixed in
    task automatic alloc_round();
        int picks [$];
        int n;
        if ($urandom_range(0, 6) != 0)
            ask(ACT_CLEAR, $urandom_range(0, 255));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 36) : $urandom_range(1, 10);
        repeat (n) picks.push_back(pick_index());
        foreach (picks[i]) begin
            ask(ACT_MARK, picks[i]);
            if ($urandom_range(0, 11) == 0)
                noise();
        end
        foreach (picks[i]) begin
            ask(ACT_ASSIGN, picks[i]);
            if ($urandom_range(0, 5) == 0)
                ask(ACT_LOOKUP, pick_index());
            if ($urandom_range(0, 11) == 0)
                noise();
        end
    endtask

    // changes flats and slots under live groups, which drives partner clashes
    task automatic rewrite_round();
        repeat ($urandom_range(1, 4))
            issue(ACT_WRITE, $urandom_range(0, TBL_DEPTH - 1), $urandom_range(0, 31),
                  $urandom_range(0, 1));
        repeat ($urandom_range(1, 10))
            ask(ACT_ASSIGN, pick_index());
    endtask

    // marks every table input, overruns the mark count, assigns each, then reassigns after a table rewrite
    task automatic fill_round();
        ask(ACT_CLEAR, $urandom_range(0, 255));
        for (int i = 0; i < TBL_DEPTH; i++)
            ask(ACT_MARK, i);
        ask(ACT_MARK, pick_index());
        for (int i = 0; i < TBL_DEPTH; i++)
            ask(ACT_ASSIGN, i);
        for (int i = 0; i < TBL_DEPTH; i++)
            issue(ACT_WRITE, i, $urandom_range(0, 31), $urandom_range(0, 1));
        for (int i = 0; i < TBL_DEPTH; i++)
            ask(ACT_ASSIGN, i);
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_PIXEL;
        cfg_wdata <= '0;
        start     <= 1'b0;
        req       <= '0;
        gaps_on   = 1'b1;
        count_now = 0;
        phase_words = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // one table input, custom on input 1 and 31
        set_config(1'b1, 1, 32'h8000_0002);
        issue(ACT_WRITE, 0, 31, 1);
        issue(ACT_WRITE, 255, 0, 0);
        for (int a = ACT_LOOKUP + 1; a < 2**ACT_W; a++)
            ask(ACT_W'(a), $urandom_range(0, 255));
        ask(ACT_LOOKUP, 0);
        ask(ACT_LOOKUP, 255);
        ask(ACT_LOOKUP, 1);
        ask(ACT_MARK, 40);
        ask(ACT_MARK, 0);
        ask(ACT_MARK, 31);
        ask(ACT_ASSIGN, 0);
        ask(ACT_ASSIGN, 31);
        ask(ACT_ASSIGN, 7);
        ask(ACT_ASSIGN, 0);
        ask(ACT_ASSIGN, 200);
        ask(ACT_CLEAR, 0);
        ask(ACT_ASSIGN, 31);
        ask(ACT_MARK, 1);

        // not a pixel stage: index passes straight through
        set_config(1'b0, 63, '1);
        ask(ACT_LOOKUP, 45);
        ask(ACT_MARK, 2);
        ask(ACT_ASSIGN, 100);

        // input count past the table depth
        set_config(1'b1, 40, $urandom);
        ask(ACT_MARK, 35);
        ask(ACT_ASSIGN, 35);
        ask(ACT_LOOKUP, 35);

        for (int i = 0; i < TBL_DEPTH; i++)
            issue(ACT_WRITE, i, $urandom_range(0, 31), $urandom_range(0, 1));

        for (int p = 0; p < PHASES; p++) begin
            bit pix;
            int cnt;
            logic [MASK_W-1:0] mask;
            int pick;
            pix  = 1'b1;
            mask = $urandom;
            case (p)
                0: cnt = 32;
                1: begin
                    cnt  = 0;
                    mask = '0;
                end
                2: begin
                    cnt  = 63;
                    mask = '1;
                end
                3: begin
                    pix = 1'b0;
                    cnt = $urandom_range(0, 63);
                end
                4: cnt = 16;
                5: cnt = 40;
                default: begin
                    pix = ($urandom_range(0, 5) != 0);
                    cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 63)
                                                      : $urandom_range(0, 32);
                end
            endcase
            set_config(pix, cnt, mask);
            gaps_on = (p % 4 != 1);
            phase_words = 0;
            if (p == 0 || p == 4 || p == 5)
                fill_round();
            while (phase_words < PHASE_WORDS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    alloc_round();
                else if (pick < 8)
                    rewrite_round();
                else
                    repeat ($urandom_range(3, 8)) noise();
            end
        end

        settle();
        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
